/* rtl/hta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hta_pkg
// Types and codes shared by the per-host IPv4 traffic accounting block.
// ----------------------------------------------------------------------------
package hta_pkg;

  // operation codes
  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_COUNTED    = 3'd0;
  localparam logic [2:0] STAT_TOO_SHORT  = 3'd1;
  localparam logic [2:0] STAT_NOT_V4     = 3'd2;
  localparam logic [2:0] STAT_HDR_TRUNC  = 3'd3;
  localparam logic [2:0] STAT_NO_PAYLOAD = 3'd4;
  localparam logic [2:0] STAT_DONE       = 3'd5;

  localparam logic [3:0]  IP_VERSION4  = 4'd4;
  localparam logic [3:0]  IHL_MASK     = 4'hF;
  localparam logic [15:0] MIN_HDR_LEN  = 16'd20;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] captured_length;
    logic [7:0]  version_ihl;
    logic [15:0] total_length;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [7:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload_bytes;
    logic [7:0]  source_slot;
    logic        source_slot_valid;
    logic [7:0]  destination_slot;
    logic        destination_slot_valid;
    logic [31:0] entry_address;
    logic [47:0] entry_bytes_in;
    logic [47:0] entry_bytes_out;
    logic [31:0] entry_packets;
    logic        entry_used;
    logic [8:0]  used_entries;
  } out_t;

  // one table slot as stored in the memory
  typedef struct packed {
    logic [31:0] addr;
    logic [47:0] rx_bytes;
    logic [47:0] tx_bytes;
    logic [31:0] packets;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_RESOLVE,
    ST_WR_SRC,
    ST_WR_DST,
    ST_RDWAIT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

/* rtl/hta_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hta_ram
// Host table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hta_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire [AW-1:0]         wr_addr,
  input  hta_pkg::entry_t      wr_data,
  input  wire                  rd_en,
  input  wire [AW-1:0]         rd_addr,
  output hta_pkg::entry_t      rd_data
);

  hta_pkg::entry_t mem [DEPTH];
  hta_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* rtl/hta_credit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hta_credit
// Saturating credit of one packet to a table entry, in or out direction.
// ----------------------------------------------------------------------------
module hta_credit (
  input  hta_pkg::entry_t ent,
  input  wire [15:0]      pay,
  input  wire             dir_in,
  output hta_pkg::entry_t result
);

  logic [47:0] base;
  logic [48:0] sum;
  logic [47:0] sat;

  always_comb begin
    base   = dir_in ? ent.rx_bytes : ent.tx_bytes;
    sum    = {1'b0, base} + 49'(pay);
    sat    = sum[48] ? '1 : sum[47:0];
    result = ent;
    if (dir_in) begin
      result.rx_bytes = sat;
    end else begin
      result.tx_bytes = sat;
    end
    if (ent.packets != '1) begin
      result.packets = ent.packets + 32'd1;
    end
  end

endmodule
`default_nettype wire

/* rtl/ipv4_host_traffic_accounting.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_host_traffic_accounting
// Per-host IPv4 byte and packet accounting over a searched host table.
// ----------------------------------------------------------------------------
//  channel  ports                         role
//  in       in_valid, in_stall, in_data   count / read / clear request item
//  out      out_valid, out_stall, out_data one result item per request
//
//  Count: the table scan reads one slot per cycle and checks source and
//  destination in the same pass. Read passes through decode, a read wait
//  and done; clear and rejected packets go from decode straight to done.
//  One item is in work at a time; the result register lets the next item
//  enter while a result waits under out_stall.
//  Reset clears the used count and control state only; table contents stay.
// ----------------------------------------------------------------------------
module ipv4_host_traffic_accounting #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  hta_pkg::in_t    in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output hta_pkg::out_t   out_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int UC_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (UC_W > 8) ? UC_W : 8;
  localparam logic [UC_W-1:0] TABLE_LIMIT = UC_W'(TABLE_ENTRIES);

  hta_pkg::state_t state_r, state_nxt;
  hta_pkg::in_t    req_r;
  hta_pkg::out_t   res_r;
  hta_pkg::out_t   out_data_r;
  logic            out_valid_r;

  logic [UC_W-1:0]  used_r;
  logic [UC_W-1:0]  issue_r;
  logic             pend_v_r;
  logic [IDX_W-1:0] pend_i_r;
  logic             src_hit_r, dst_hit_r;
  logic [IDX_W-1:0] src_slot_r, dst_slot_r;
  hta_pkg::entry_t  src_ent_r, dst_ent_r;
  logic             src_v_r, dst_v_r, same_r;
  logic [15:0]      pay_r;

  // header checks
  logic [5:0]  hlen;
  logic [15:0] hlen16;
  logic [2:0]  chk_status;
  logic [15:0] pay;

  // memory ports
  logic             ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
  hta_pkg::entry_t  ram_wr_data, ram_rd_data;

  // scan
  logic s_match, d_match, all_found, exhausted, scan_issue;

  // resolve
  logic             src_ins, src_v, same, dst_ins, dst_v;
  logic [IDX_W-1:0] src_slot, dst_slot;
  logic [UC_W-1:0]  used_a;

  // read
  logic read_ok;

  hta_pkg::entry_t src_cred, dst_cred, dst_base;

  // fresh entries and result words
  hta_pkg::entry_t src_new, dst_new;
  hta_pkg::out_t   res_init, res_fin;

  hta_ram #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign dst_base = same_r ? src_ent_r : dst_ent_r;

  hta_credit u_cred_src (
    .ent    (src_ent_r),
    .pay    (pay_r),
    .dir_in (1'b0),
    .result (src_cred)
  );

  hta_credit u_cred_dst (
    .ent    (dst_base),
    .pay    (pay_r),
    .dir_in (1'b1),
    .result (dst_cred)
  );

  always_comb begin
    hlen   = {req_r.version_ihl[3:0] & hta_pkg::IHL_MASK, 2'b00};
    hlen16 = 16'(hlen);
    pay    = req_r.total_length - hlen16;
    if (req_r.captured_length < hta_pkg::MIN_HDR_LEN) begin
      chk_status = hta_pkg::STAT_TOO_SHORT;
    end else if (req_r.version_ihl[7:4] != hta_pkg::IP_VERSION4) begin
      chk_status = hta_pkg::STAT_NOT_V4;
    end else if (req_r.captured_length < hlen16) begin
      chk_status = hta_pkg::STAT_HDR_TRUNC;
    end else if (req_r.total_length <= hlen16) begin
      chk_status = hta_pkg::STAT_NO_PAYLOAD;
    end else begin
      chk_status = hta_pkg::STAT_COUNTED;
    end
  end

  always_comb begin
    res_init = '0;
    if (req_r.operation == hta_pkg::OP_COUNT) begin
      res_init.status = chk_status;
    end else begin
      res_init.status = hta_pkg::STAT_DONE;
    end
    res_fin              = res_r;
    res_fin.used_entries = 9'(used_r);
    src_new              = '0;
    src_new.addr         = req_r.source_address;
    dst_new              = '0;
    dst_new.addr         = req_r.destination_address;
  end

  assign read_ok = CMP_W'(req_r.read_index) < CMP_W'(used_r);

  // scan compares the slot read in the previous cycle
  assign s_match   = pend_v_r && !src_hit_r &&
                     (ram_rd_data.addr == req_r.source_address);
  assign d_match   = pend_v_r && !dst_hit_r &&
                     (ram_rd_data.addr == req_r.destination_address);
  assign all_found = (src_hit_r || s_match) && (dst_hit_r || d_match);
  assign exhausted = !pend_v_r && (issue_r >= used_r);
  assign scan_issue = (issue_r < used_r) && !all_found;

  // source is placed before destination, as in sequential lookups
  always_comb begin
    src_ins  = !src_hit_r && (used_r < TABLE_LIMIT);
    src_v    = src_hit_r || src_ins;
    src_slot = src_hit_r ? src_slot_r : used_r[IDX_W-1:0];
    used_a   = used_r + UC_W'(src_ins);
    same     = src_v && (req_r.source_address == req_r.destination_address);
    dst_ins  = !dst_hit_r && !same && (used_a < TABLE_LIMIT);
    dst_v    = dst_hit_r || same || dst_ins;
    if (dst_hit_r) begin
      dst_slot = dst_slot_r;
    end else if (same) begin
      dst_slot = src_slot;
    end else begin
      dst_slot = used_a[IDX_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hta_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = hta_pkg::ST_DECODE;
        end
      end
      hta_pkg::ST_DECODE: begin
        priority if (req_r.operation == hta_pkg::OP_COUNT &&
                     chk_status == hta_pkg::STAT_COUNTED) begin
          state_nxt = hta_pkg::ST_SCAN;
        end else if (req_r.operation == hta_pkg::OP_READ && read_ok) begin
          state_nxt = hta_pkg::ST_RDWAIT;
        end else begin
          state_nxt = hta_pkg::ST_DONE;
        end
      end
      hta_pkg::ST_SCAN: begin
        if (all_found || exhausted) begin
          state_nxt = hta_pkg::ST_RESOLVE;
        end
      end
      hta_pkg::ST_RESOLVE: state_nxt = hta_pkg::ST_WR_SRC;
      hta_pkg::ST_WR_SRC:  state_nxt = hta_pkg::ST_WR_DST;
      hta_pkg::ST_WR_DST:  state_nxt = hta_pkg::ST_DONE;
      hta_pkg::ST_RDWAIT:  state_nxt = hta_pkg::ST_DONE;
      hta_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = hta_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hta_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall    = 1'b1;
    ram_rd_en   = 1'b0;
    ram_rd_addr = issue_r[IDX_W-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = src_slot_r;
    ram_wr_data = src_cred;
    unique case (state_r)
      // no item is taken while reset is held
      hta_pkg::ST_IDLE: in_stall = !rst_n;
      hta_pkg::ST_DECODE: begin
        ram_rd_en   = (req_r.operation == hta_pkg::OP_READ) && read_ok;
        ram_rd_addr = IDX_W'(req_r.read_index);
      end
      hta_pkg::ST_SCAN: ram_rd_en = scan_issue;
      hta_pkg::ST_WR_SRC: ram_wr_en = src_v_r;
      hta_pkg::ST_WR_DST: begin
        ram_wr_en   = dst_v_r;
        ram_wr_addr = dst_slot_r;
        ram_wr_data = dst_cred;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hta_pkg::ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == hta_pkg::ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == hta_pkg::ST_DECODE) begin
        pend_v_r <= 1'b0;
        if (req_r.operation == hta_pkg::OP_CLEAR) begin
          used_r <= '0;
        end
      end else if (state_r == hta_pkg::ST_SCAN) begin
        pend_v_r <= scan_issue;
      end else if (state_r == hta_pkg::ST_RESOLVE) begin
        used_r <= used_a + UC_W'(dst_ins);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      hta_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_r <= in_data;
        end
      end
      hta_pkg::ST_DECODE: begin
        issue_r   <= '0;
        src_hit_r <= 1'b0;
        dst_hit_r <= 1'b0;
        pay_r     <= pay;
        res_r     <= res_init;
      end
      hta_pkg::ST_SCAN: begin
        if (s_match) begin
          src_hit_r  <= 1'b1;
          src_slot_r <= pend_i_r;
          src_ent_r  <= ram_rd_data;
        end
        if (d_match) begin
          dst_hit_r  <= 1'b1;
          dst_slot_r <= pend_i_r;
          dst_ent_r  <= ram_rd_data;
        end
        if (scan_issue) begin
          pend_i_r <= issue_r[IDX_W-1:0];
          issue_r  <= issue_r + UC_W'(1);
        end
      end
      hta_pkg::ST_RESOLVE: begin
        src_v_r    <= src_v;
        dst_v_r    <= dst_v;
        same_r     <= same;
        src_slot_r <= src_slot;
        dst_slot_r <= dst_slot;
        if (!src_hit_r) begin
          src_ent_r <= src_new;
        end
        if (!dst_hit_r) begin
          dst_ent_r <= dst_new;
        end
      end
      hta_pkg::ST_WR_SRC: begin
        // destination credit of the same host builds on this value
        src_ent_r <= src_cred;
      end
      hta_pkg::ST_WR_DST: begin
        res_r.payload_bytes          <= pay_r;
        res_r.source_slot_valid      <= src_v_r;
        res_r.destination_slot_valid <= dst_v_r;
        res_r.source_slot            <= src_v_r ? 8'(src_slot_r) : 8'd0;
        res_r.destination_slot       <= dst_v_r ? 8'(dst_slot_r) : 8'd0;
      end
      hta_pkg::ST_RDWAIT: begin
        res_r.entry_address   <= ram_rd_data.addr;
        res_r.entry_bytes_in  <= ram_rd_data.rx_bytes;
        res_r.entry_bytes_out <= ram_rd_data.tx_bytes;
        res_r.entry_packets   <= ram_rd_data.packets;
        res_r.entry_used      <= 1'b1;
      end
      hta_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_r <= res_fin;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= TABLE_LIMIT)
    else $error("used count above table size");

  a_write_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (state_r == hta_pkg::ST_WR_SRC || state_r == hta_pkg::ST_WR_DST))
    else $error("table write outside update states");

  a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == hta_pkg::ST_DECODE)
    else $error("accepted item not decoded");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hta_pkg::ST_SCAN) |-> issue_r <= used_r)
    else $error("scan index beyond used entries");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hta_pkg::ST_DONE && state_nxt == hta_pkg::ST_IDLE) |=> out_valid_r)
    else $error("finished item produced no result");

endmodule
`default_nettype wire

/* tb/tb_ipv4_host_traffic_accounting.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_host_traffic_accounting
// Drives count, read and clear requests into the host accounting block and
// checks every result against a host table kept inside the bench.
// ----------------------------------------------------------------------------
module tb_ipv4_host_traffic_accounting;

  localparam int TABLE_ENTRIES = 256;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int TAIL_CYCLES   = 300;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  hta_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hta_pkg::out_t out_data;

  ipv4_host_traffic_accounting #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // bench copy of the host table
  logic [31:0] acct_addr [TABLE_ENTRIES];
  logic [47:0] acct_in   [TABLE_ENTRIES];
  logic [47:0] acct_out  [TABLE_ENTRIES];
  logic [31:0] acct_pkts [TABLE_ENTRIES];
  int          acct_used = 0;

  hta_pkg::out_t pending_results[$];
  hta_pkg::out_t head_result;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic [31:0] host_pool [512];
  int          pool_size = 1;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_ipv4_host_traffic_accounting: errors");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [15:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {33'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  // find the host, or append it with zero counters while room remains
  function automatic bit locate_host(input logic [31:0] addr, output int slot);
    slot = 0;
    for (int i = 0; i < acct_used; i++) begin
      if (acct_addr[i] == addr) begin
        slot = i;
        return 1'b1;
      end
    end
    if (acct_used >= TABLE_ENTRIES) return 1'b0;
    slot = acct_used;
    acct_addr[slot] = addr;
    acct_in[slot]   = '0;
    acct_out[slot]  = '0;
    acct_pkts[slot] = '0;
    acct_used++;
    return 1'b1;
  endfunction

  function automatic void account_item(input hta_pkg::in_t it);
    hta_pkg::out_t r;
    int hlen, ss, ds;
    bit sv, dv;
    logic [15:0] pay;
    r = '0;
    hlen = int'(it.version_ihl[3:0] & hta_pkg::IHL_MASK) * 4;
    case (it.operation)
      hta_pkg::OP_COUNT: begin
        if (it.captured_length < hta_pkg::MIN_HDR_LEN) begin
          r.status = hta_pkg::STAT_TOO_SHORT;
        end else if (it.version_ihl[7:4] != hta_pkg::IP_VERSION4) begin
          r.status = hta_pkg::STAT_NOT_V4;
        end else if (int'(it.captured_length) < hlen) begin
          r.status = hta_pkg::STAT_HDR_TRUNC;
        end else if (int'(it.total_length) <= hlen) begin
          r.status = hta_pkg::STAT_NO_PAYLOAD;
        end else begin
          pay = it.total_length - 16'(hlen);
          sv = locate_host(it.source_address, ss);
          dv = locate_host(it.destination_address, ds);
          if (sv) begin
            acct_out[ss]  = sat_add48(acct_out[ss], pay);
            acct_pkts[ss] = sat_inc32(acct_pkts[ss]);
          end
          if (dv) begin
            acct_in[ds]   = sat_add48(acct_in[ds], pay);
            acct_pkts[ds] = sat_inc32(acct_pkts[ds]);
          end
          r.status                 = hta_pkg::STAT_COUNTED;
          r.payload_bytes          = pay;
          r.source_slot            = sv ? 8'(ss) : 8'd0;
          r.source_slot_valid      = sv;
          r.destination_slot       = dv ? 8'(ds) : 8'd0;
          r.destination_slot_valid = dv;
        end
      end
      hta_pkg::OP_READ: begin
        r.status = hta_pkg::STAT_DONE;
        if (int'(it.read_index) < acct_used && int'(it.read_index) < TABLE_ENTRIES) begin
          r.entry_address   = acct_addr[it.read_index];
          r.entry_bytes_in  = acct_in[it.read_index];
          r.entry_bytes_out = acct_out[it.read_index];
          r.entry_packets   = acct_pkts[it.read_index];
          r.entry_used      = 1'b1;
        end
      end
      hta_pkg::OP_CLEAR: begin
        acct_used = 0;
        r.status = hta_pkg::STAT_DONE;
      end
      default: r.status = hta_pkg::STAT_DONE;
    endcase
    r.used_entries = 9'(acct_used);
    pending_results.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing outstanding: %h", out_data);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("status", head_result.status, out_data.status);
        check_field("payload_bytes", head_result.payload_bytes, out_data.payload_bytes);
        check_field("source_slot", head_result.source_slot, out_data.source_slot);
        check_field("source_slot_valid", head_result.source_slot_valid,
                    out_data.source_slot_valid);
        check_field("destination_slot", head_result.destination_slot,
                    out_data.destination_slot);
        check_field("destination_slot_valid", head_result.destination_slot_valid,
                    out_data.destination_slot_valid);
        check_field("entry_address", head_result.entry_address, out_data.entry_address);
        check_field("entry_bytes_in", head_result.entry_bytes_in, out_data.entry_bytes_in);
        check_field("entry_bytes_out", head_result.entry_bytes_out,
                    out_data.entry_bytes_out);
        check_field("entry_packets", head_result.entry_packets, out_data.entry_packets);
        check_field("entry_used", head_result.entry_used, out_data.entry_used);
        check_field("used_entries", head_result.used_entries, out_data.used_entries);
      end
    end
  end

  // entered and left just after a falling edge
  task automatic send_item(input hta_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    account_item(item);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_idling(input int sender, input int receiver);
    send_idle_pct = sender;
    stall_pct     = receiver;
  endtask

  function automatic hta_pkg::in_t pkt(input logic [31:0] src, input logic [31:0] dst,
                                       input logic [15:0] cap, input logic [7:0] vihl,
                                       input logic [15:0] tot);
    hta_pkg::in_t it;
    it = '0;
    it.operation           = hta_pkg::OP_COUNT;
    it.captured_length     = cap;
    it.version_ihl         = vihl;
    it.total_length        = tot;
    it.source_address      = src;
    it.destination_address = dst;
    return it;
  endfunction

  function automatic hta_pkg::in_t req(input logic [1:0] op, input logic [7:0] idx);
    hta_pkg::in_t it;
    it = '0;
    it.operation  = op;
    it.read_index = idx;
    return it;
  endfunction

  function automatic logic [31:0] pick_host();
    if ($urandom_range(19) == 0) return $urandom;
    return host_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  function automatic hta_pkg::in_t random_item();
    hta_pkg::in_t it;
    int r, v, ihl, hlen, lo;
    it.operation           = hta_pkg::OP_COUNT;
    it.captured_length     = $urandom;
    it.version_ihl         = $urandom;
    it.total_length        = $urandom;
    it.source_address      = $urandom;
    it.destination_address = $urandom;
    it.read_index          = $urandom;
    r = $urandom_range(99);
    if (r < 60) begin
      // well-formed packet, mostly between hosts of the pool
      ihl  = ($urandom_range(9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
      hlen = ihl * 4;
      lo   = (hlen > 20) ? hlen : 20;
      it.version_ihl     = {hta_pkg::IP_VERSION4, 4'(ihl)};
      it.captured_length = ($urandom_range(3) == 0) ? 16'(lo) : 16'($urandom_range(lo, 65535));
      it.total_length    = ($urandom_range(1) == 0) ? 16'($urandom_range(hlen + 1, hlen + 1500))
                                                    : 16'($urandom_range(hlen + 1, 65535));
      it.source_address      = pick_host();
      it.destination_address = ($urandom_range(9) == 0) ? it.source_address : pick_host();
    end else if (r < 75) begin
      it.operation = hta_pkg::OP_READ;
      if (acct_used > 0 && $urandom_range(3) != 0)
        it.read_index = 8'($urandom_range(0, acct_used - 1));
    end else if (r < 77) begin
      it.operation = hta_pkg::OP_CLEAR;
    end else if (r < 80) begin
      it.operation = OP_UNUSED;
    end else begin
      case ($urandom_range(4))
        0: it.captured_length = 16'($urandom_range(0, 19));
        1: begin
          v = $urandom_range(0, 14);
          if (v >= 4) v++;
          it.version_ihl[7:4] = 4'(v);
          it.captured_length  = 16'($urandom_range(20, 65535));
        end
        2: begin
          ihl  = $urandom_range(6, 15);
          hlen = ihl * 4;
          it.version_ihl     = {hta_pkg::IP_VERSION4, 4'(ihl)};
          it.captured_length = 16'($urandom_range(20, hlen - 1));
        end
        3: begin
          ihl  = $urandom_range(0, 15);
          hlen = ihl * 4;
          lo   = (hlen > 20) ? hlen : 20;
          it.version_ihl     = {hta_pkg::IP_VERSION4, 4'(ihl)};
          it.captured_length = 16'($urandom_range(lo, 65535));
          it.total_length    = 16'($urandom_range(0, hlen));
        end
        default: it.operation = 2'($urandom_range(0, 3));
      endcase
    end
    return it;
  endfunction

  task automatic test_header_checks();
    set_idling(0, 0);
    send_item(pkt(32'hC0A80001, 32'h0A000001, 16'd0,  8'h45, 16'd100));
    send_item(pkt(32'hC0A80001, 32'h0A000001, 16'd19, 8'h45, 16'd100));
    send_item(pkt(32'hC0A80001, 32'h0A000001, 16'd20, 8'h65, 16'd100));
    send_item(pkt(32'hC0A80001, 32'h0A000001, 16'd20, 8'hF5, 16'd100));
    send_item(pkt(32'hC0A80001, 32'h0A000001, 16'd59, 8'h4F, 16'd100));
    send_item(pkt(32'hC0A80001, 32'h0A000001, 16'd60, 8'h4F, 16'd60));
    send_item(pkt(32'hC0A80001, 32'h0A000001, 16'd20, 8'h45, 16'd20));
    send_item(pkt(32'hC0A80001, 32'h0A000001, 16'd20, 8'h40, 16'd0));
  endtask

  task automatic test_counting_and_reads();
    set_idling(70, 0);
    send_item(pkt(32'hC0A80001, 32'h0A000001, 16'hFFFF, 8'h4F, 16'hFFFF));
    send_item(pkt(32'hC0A80001, 32'h0A000001, 16'd20, 8'h45, 16'd21));
    send_item(pkt(32'h7F000001, 32'h7F000001, 16'd100, 8'h45, 16'd1000));
    // header length field below five taken as it stands
    send_item(pkt(32'hFFFFFFFF, 32'h00000000, 16'd20, 8'h40, 16'd1));
    send_item(pkt(32'h0A000001, 32'hC0A80001, 16'd20, 8'h44, 16'd17));
    for (int i = 0; i < 5; i++) send_item(req(hta_pkg::OP_READ, 8'(i)));
    send_item(req(OP_UNUSED, 8'd0));
  endtask

  task automatic test_clear();
    set_idling(0, 70);
    send_item(req(hta_pkg::OP_CLEAR, 8'd0));
    send_item(req(hta_pkg::OP_READ, 8'd0));
    send_item(req(hta_pkg::OP_READ, 8'd4));
    send_item(pkt(32'h08080808, 32'hC0A80001, 16'd1500, 8'h45, 16'd1500));
    send_item(req(hta_pkg::OP_READ, 8'd0));
    send_item(req(hta_pkg::OP_READ, 8'd1));
  endtask

  task automatic test_table_full();
    logic [31:0] base;
    base = $urandom;
    set_idling(36, 36);
    send_item(req(hta_pkg::OP_CLEAR, 8'd0));
    for (int k = 0; k < TABLE_ENTRIES / 2; k++)
      send_item(pkt(base + 32'(2 * k), base + 32'(2 * k + 1), 16'd1500, 8'h45,
                    16'($urandom_range(21, 1500))));
    send_item(pkt(base, base + 32'd300, 16'd1500, 8'h45, 16'd1500));
    send_item(pkt(base + 32'd301, base + 32'd1, 16'd1500, 8'h45, 16'd1500));
    send_item(pkt(base + 32'd302, base + 32'd303, 16'd1500, 8'h45, 16'd1500));
    send_item(pkt(base + 32'd304, base + 32'd304, 16'd1500, 8'h45, 16'd1500));
    send_item(pkt(base + 32'd5, base + 32'd5, 16'd1500, 8'h45, 16'd1500));
    send_item(req(hta_pkg::OP_READ, 8'd0));
    send_item(req(hta_pkg::OP_READ, 8'd5));
    send_item(req(hta_pkg::OP_READ, 8'd255));
    send_item(req(hta_pkg::OP_CLEAR, 8'd0));
    send_item(req(hta_pkg::OP_READ, 8'd255));
    // sender holds off until the block has answered everything
    drain();
  endtask

  task automatic test_random_traffic();
    int sender_pct [4]  = '{0, 70, 0, 36};
    int receiver_pct [4] = '{0, 0, 70, 36};
    int pool_sizes [4]  = '{6, 40, 300, 24};
    for (int ph = 0; ph < 4; ph++) begin
      set_idling(sender_pct[ph], receiver_pct[ph]);
      pool_size = pool_sizes[ph];
      for (int i = 0; i < pool_size; i++) host_pool[i] = $urandom;
      repeat (255) send_item(random_item());
      drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_header_checks();
    test_counting_and_reads();
    test_clear();
    test_table_full();
    test_random_traffic();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_ipv4_host_traffic_accounting: clean");
    end else begin
      $display("tb_ipv4_host_traffic_accounting: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hta_pkg.sv
rtl/hta_ram.sv
rtl/hta_credit.sv
rtl/ipv4_host_traffic_accounting.sv
tb/tb_ipv4_host_traffic_accounting.sv
